// ===== design/phased_timeline_event_sequencer_macros.svh =====
// Assertion macros for the phased timeline event sequencer.
// Included by modules that carry concurrent checks.
`ifndef PHASED_TIMELINE_EVENT_SEQUENCER_MACROS_SVH
`define PHASED_TIMELINE_EVENT_SEQUENCER_MACROS_SVH
`ifndef ASSERT_OFF
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/pts_pkg.sv =====
// Shared types and constants for the phased timeline event sequencer.
// No dependencies.
package pts_pkg;
  localparam int MaxPhases = 16;
  localparam int EventsPerPhase = 8;
  localparam int TimeWidth = 24;
  localparam int PhW = $clog2(MaxPhases);
  localparam int EsW = $clog2(EventsPerPhase);
  localparam int SlotW = PhW + EsW;
  localparam int MinDuration = 16;
  localparam int MaxFired = 63;
  localparam int FcW = 6;

  typedef enum logic [2:0] {
    OP_LOAD_DUR = 3'd0, OP_LOAD_EVT = 3'd1, OP_PLAY = 3'd2, OP_PAUSE = 3'd3,
    OP_RESUME = 3'd4, OP_STOP = 3'd5, OP_TICK = 3'd6, OP_NONE = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0, MODE_PLAYING = 2'd1, MODE_PAUSED = 2'd2
  } mode_t;

  typedef enum logic [0:0] { CFG_PHASE_COUNT = 1'b0, CFG_SKIP_ALLOWED = 1'b1 } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PHASE, ST_SCAN, ST_EMIT, ST_NEXT, ST_STATUS
  } state_t;

  typedef struct packed {
    logic exec;       // apply non-tick request
    logic phase_start;// compute window for current phase
    logic scan_step;  // advance slot
    logic emit;       // present fired event
    logic next_phase; // commit phase step
    logic status;     // present status item
    logic clr_drop;
  } cmd_t;

  typedef struct packed {
    logic tick_go;    // tick request that moves
    logic phase_end;  // no more work in tick
    logic hit;        // current slot fires
    logic slot_last;
    logic win_final;  // window ends inside phase
    logic out_free;
  } sts_t;
endpackage

// ===== design/pts_if.sv =====
// Valid/ready channel interfaces for the sequencer.
// Depends on pts_pkg.
interface pts_in_if;
  import pts_pkg::*;
  logic valid, ready;
  logic [2:0] operation;
  logic [3:0] phase_slot;
  logic [2:0] event_slot;
  logic event_present;
  logic [15:0] event_tag;
  logic signed [23:0] time_value;
  modport source (output valid, operation, phase_slot, event_slot, event_present,
                  event_tag, time_value, input ready);
  modport sink (input valid, operation, phase_slot, event_slot, event_present,
                event_tag, time_value, output ready);
endinterface

interface pts_out_if;
  logic valid, ready;
  logic item_kind;
  logic [15:0] fired_tag;
  logic [3:0] fired_phase;
  logic signed [23:0] fired_offset;
  logic run_last;
  logic [1:0] mode;
  logic finished;
  logic [4:0] current_phase;
  logic [22:0] current_offset;
  logic events_dropped;
  modport source (output valid, item_kind, fired_tag, fired_phase, fired_offset,
                  run_last, mode, finished, current_phase, current_offset,
                  events_dropped, input ready);
  modport sink (input valid, item_kind, fired_tag, fired_phase, fired_offset,
                run_last, mode, finished, current_phase, current_offset,
                events_dropped, output ready);
endinterface

interface pts_cfg_if;
  logic valid, ready;
  logic [0:0] index;
  logic [4:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/phased_timeline_event_sequencer.sv =====
// Top level of the phased timeline event sequencer.
// Depends on pts_pkg, pts_if, pts_ctrl and pts_dp.
// One request at a time. A load, play, pause, resume or stop passes through
// the status state into the output register; once its status item is
// presented, the next request can already be taken. A tick sweeps each phase
// it covers with a window setup, a scan of every event slot and a commit,
// plus an emit step per fired event, a status step and any result-side stalls;
// the single slot-table read port sets this. No reset clearing pass is needed.
module phased_timeline_event_sequencer
  import pts_pkg::*;
(
  input logic clk,
  input logic rst_n,
  pts_in_if.sink in_ch,
  pts_out_if.source out_ch,
  pts_cfg_if.sink cfg_ch
);
  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  pts_ctrl u_ctrl (.clk, .rst_n, .in_fire, .sts, .in_ready(in_ch.ready), .cmd);
  pts_dp u_dp (.clk, .rst_n, .cmd, .sts, .in_ch, .out_ch, .cfg_ch);
endmodule

// ===== design/pts_ctrl.sv =====
// Controller FSM for the sequencer: sequences requests, phases and slot scan.
// Depends on pts_pkg and the macros header.
`include "phased_timeline_event_sequencer_macros.svh"
module pts_ctrl
  import pts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = sts.tick_go ? ST_PHASE : ST_STATUS;
      ST_PHASE: state_nxt = sts.phase_end ? ST_STATUS : ST_SCAN;
      ST_SCAN: begin
        if (sts.hit) state_nxt = ST_EMIT;
        else if (sts.slot_last) state_nxt = ST_NEXT;
      end
      ST_EMIT: if (sts.out_free) state_nxt = sts.slot_last ? ST_NEXT : ST_SCAN;
      ST_NEXT: state_nxt = sts.win_final ? ST_STATUS : ST_PHASE;
      ST_STATUS: if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_fire;
        cmd.clr_drop = in_fire;
      end
      ST_PHASE: cmd.phase_start = 1'b1;
      ST_SCAN: cmd.scan_step = !sts.hit;
      ST_EMIT: begin
        cmd.emit = sts.out_free;
        cmd.scan_step = sts.out_free;
      end
      ST_NEXT: cmd.next_phase = 1'b1;
      ST_STATUS: cmd.status = sts.out_free;
      default: ;
    endcase
  end

  `PTS_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> state_r == ST_IDLE, "ready outside idle")
  `PTS_ASSERT(a_accept_leaves, clk, rst_n, in_fire |=> state_r != ST_IDLE, "accept stayed idle")
  `PTS_ASSERT(a_emit_onehot, clk, rst_n, $onehot0({cmd.emit, cmd.status, cmd.exec}), "cmd clash")
endmodule

// ===== design/pts_dp.sv =====
// Datapath: tables, play state, window compare and output register.
// Depends on pts_pkg and the macros header.
`include "phased_timeline_event_sequencer_macros.svh"
module pts_dp
  import pts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  output sts_t sts,
  pts_in_if.sink  in_ch,
  pts_out_if.source out_ch,
  pts_cfg_if.sink cfg_ch
);
  localparam int SlotN = MaxPhases * EventsPerPhase;

  logic signed [TimeWidth-1:0] dur_mem [MaxPhases];
  logic signed [TimeWidth-1:0] off_mem [SlotN];
  logic [15:0] tag_mem [SlotN];
  logic [SlotN-1:0] vld_r;

  logic [4:0] pcount_r;
  logic skip_r;
  mode_t mode_r;
  logic done_r, drop_r;
  logic [4:0] pidx_r;
  logic [TimeWidth-1:0] pos_r;
  logic [TimeWidth-1:0] rem_r;
  logic [TimeWidth-1:0] prev_r, upto_r;
  logic final_r, ended_r;
  logic [EsW-1:0] slot_r;
  logic [FcW-1:0] fcnt_r;
  logic signed [TimeWidth-1:0] rd_off_r;
  logic [15:0] rd_tag_r;
  logic rd_vld_r;
  logic signed [TimeWidth-1:0] dur_rd_r;

  logic ov_r;
  logic o_kind_r, o_last_r, o_fin_r, o_drop_r;
  logic [15:0] o_tag_r;
  logic [3:0] o_ph_r;
  logic signed [TimeWidth-1:0] o_off_r;
  logic [1:0] o_mode_r;
  logic [4:0] o_cph_r;
  logic [22:0] o_coff_r;

  logic [4:0] act_cnt;
  logic [SlotW-1:0] wr_idx, rd_idx;
  logic [EsW-1:0] slot_nxt;
  logic [PhW-1:0] dur_ra;
  logic [TimeWidth:0] raw;
  logic [TimeWidth-1:0] dur_eff;
  logic hit;
  op_t op;

  assign op = op_t'(in_ch.operation);
  assign act_cnt = (pcount_r > 5'(MaxPhases)) ? 5'(MaxPhases) : pcount_r;
  assign wr_idx = {in_ch.phase_slot, in_ch.event_slot};
  assign rd_idx = {pidx_r[PhW-1:0], slot_nxt};
  assign dur_ra = (cmd.next_phase && !final_r) ? pidx_r[PhW-1:0] + 1'b1 : pidx_r[PhW-1:0];
  assign dur_eff = (dur_rd_r < TimeWidth'(MinDuration)) ? TimeWidth'(MinDuration) : dur_rd_r;
  assign raw = {1'b0, pos_r} + {1'b0, rem_r};
  assign cfg_ch.ready = 1'b1;

  // slot address for the next scan cycle, so the registered read lines up
  always_comb begin
    slot_nxt = slot_r;
    if (cmd.phase_start) slot_nxt = '0;
    else if (cmd.scan_step && !sts.slot_last) slot_nxt = slot_r + 1'b1;
  end

  always_comb begin
    if (prev_r == '0) hit = rd_vld_r && !rd_off_r[TimeWidth-1] &&
                            $signed(rd_off_r) <= $signed(upto_r);
    else hit = rd_vld_r && ($signed(rd_off_r) > $signed(prev_r)) &&
               ($signed(rd_off_r) <= $signed(upto_r));
  end

  assign sts.tick_go = op == OP_TICK && mode_r == MODE_PLAYING &&
                       !in_ch.time_value[TimeWidth-1] && in_ch.time_value != '0;
  assign sts.phase_end = ended_r || mode_r != MODE_PLAYING || pidx_r >= act_cnt;
  assign sts.hit = hit;
  assign sts.slot_last = slot_r == EsW'(EventsPerPhase - 1);
  assign sts.win_final = final_r;
  assign sts.out_free = !ov_r || out_ch.ready;

  // memory write and registered reads
  always_ff @(posedge clk) begin
    if (cmd.exec && mode_r == MODE_IDLE && op == OP_LOAD_DUR)
      dur_mem[in_ch.phase_slot] <= in_ch.time_value;
    if (cmd.exec && mode_r == MODE_IDLE && op == OP_LOAD_EVT) begin
      off_mem[wr_idx] <= in_ch.time_value;
      tag_mem[wr_idx] <= in_ch.event_tag;
    end
    dur_rd_r <= dur_mem[dur_ra];
    rd_off_r <= off_mem[rd_idx];
    rd_tag_r <= tag_mem[rd_idx];
    rd_vld_r <= vld_r[rd_idx];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0; pcount_r <= '0; skip_r <= 1'b1; mode_r <= MODE_IDLE;
      done_r <= 1'b0; drop_r <= 1'b0; pidx_r <= '0; pos_r <= '0; rem_r <= '0;
      prev_r <= '0; upto_r <= '0; final_r <= 1'b0; ended_r <= 1'b0;
      slot_r <= '0; fcnt_r <= '0; ov_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_idx_t'(cfg_ch.index))
          CFG_PHASE_COUNT: pcount_r <= cfg_ch.data;
          CFG_SKIP_ALLOWED: skip_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if ((cmd.emit && fcnt_r < FcW'(MaxFired)) || cmd.status) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      if (cmd.clr_drop) begin
        drop_r <= 1'b0; fcnt_r <= '0; ended_r <= 1'b0;
        rem_r <= in_ch.time_value;
      end
      if (cmd.exec) begin
        unique case (op)
          OP_LOAD_EVT: if (mode_r == MODE_IDLE) vld_r[wr_idx] <= in_ch.event_present;
          OP_PLAY: begin
            pidx_r <= '0; pos_r <= '0;
            done_r <= act_cnt == '0;
            mode_r <= act_cnt == '0 ? MODE_IDLE : MODE_PLAYING;
          end
          OP_PAUSE: if (mode_r == MODE_PLAYING) mode_r <= MODE_PAUSED;
          OP_RESUME: if (mode_r == MODE_PAUSED) mode_r <= MODE_PLAYING;
          OP_STOP: if (mode_r != MODE_IDLE && skip_r) begin
            mode_r <= MODE_IDLE; done_r <= 1'b0; pidx_r <= '0; pos_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.phase_start) begin
        if (pidx_r >= act_cnt) begin
          mode_r <= MODE_IDLE; done_r <= 1'b1;
        end else begin
          prev_r <= pos_r;
          final_r <= raw < {1'b0, dur_eff};
          upto_r <= (raw < {1'b0, dur_eff}) ? raw[TimeWidth-1:0] : dur_eff;
        end
      end
      slot_r <= slot_nxt;
      if (cmd.emit) begin
        if (fcnt_r < FcW'(MaxFired)) fcnt_r <= fcnt_r + 1'b1;
        else drop_r <= 1'b1;
      end
      if (cmd.next_phase) begin
        if (final_r) pos_r <= upto_r;
        else begin
          rem_r <= raw[TimeWidth-1:0] - dur_eff;
          pos_r <= '0;
          pidx_r <= pidx_r + 1'b1;
          if (pidx_r + 1'b1 >= act_cnt) begin
            mode_r <= MODE_IDLE; done_r <= 1'b1; ended_r <= 1'b1;
          end else if (raw[TimeWidth-1:0] == dur_eff) ended_r <= 1'b1;
        end
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit && fcnt_r < FcW'(MaxFired)) begin
      o_kind_r <= 1'b0; o_tag_r <= rd_tag_r; o_ph_r <= pidx_r[3:0];
      o_off_r <= rd_off_r; o_last_r <= 1'b0; o_mode_r <= '0; o_fin_r <= 1'b0;
      o_cph_r <= '0; o_coff_r <= '0; o_drop_r <= 1'b0;
    end else if (cmd.status) begin
      o_kind_r <= 1'b1; o_tag_r <= '0; o_ph_r <= '0; o_off_r <= '0;
      o_last_r <= 1'b1; o_mode_r <= mode_r; o_fin_r <= done_r;
      o_cph_r <= pidx_r; o_coff_r <= pos_r[22:0]; o_drop_r <= drop_r;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.item_kind = o_kind_r;
  assign out_ch.fired_tag = o_tag_r;
  assign out_ch.fired_phase = o_ph_r;
  assign out_ch.fired_offset = o_off_r;
  assign out_ch.run_last = o_last_r;
  assign out_ch.mode = o_mode_r;
  assign out_ch.finished = o_fin_r;
  assign out_ch.current_phase = o_cph_r;
  assign out_ch.current_offset = o_coff_r;
  assign out_ch.events_dropped = o_drop_r;

  `PTS_ASSERT(a_fcnt_cap, clk, rst_n, fcnt_r <= FcW'(MaxFired), "fired count overrun")
  `PTS_ASSERT(a_mode_legal_pidx, clk, rst_n, mode_r == MODE_PLAYING |-> pidx_r < 5'(MaxPhases),
              "playing past table")
  `PTS_ASSERT(a_status_flag, clk, rst_n, (ov_r && o_last_r) |-> o_kind_r, "last not status")
endmodule

// ===== tb/tb_phased_timeline_event_sequencer.sv =====
// Testbench for phased_timeline_event_sequencer: drives load, play, pause,
// resume, stop and tick requests with random idling and checks every result.
// Depends on pts_pkg and the channel interfaces in pts_if.
module tb_phased_timeline_event_sequencer;
  import pts_pkg::*;

  typedef struct {
    logic        item_kind;
    logic [15:0] fired_tag;
    logic [3:0]  fired_phase;
    logic [23:0] fired_offset;
    logic        run_last;
    logic [1:0]  mode;
    logic        finished;
    logic [4:0]  current_phase;
    logic [22:0] current_offset;
    logic        events_dropped;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  pts_in_if  in_ch();
  pts_out_if out_ch();
  pts_cfg_if cfg_ch();

  phased_timeline_event_sequencer u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // sequencer shadow state
  logic [4:0]  sh_phase_count = 5'd0;
  logic        sh_skip = 1'b1;
  int          sh_dur [MaxPhases];
  int          sh_ev_off [MaxPhases*EventsPerPhase];
  logic [15:0] sh_ev_tag [MaxPhases*EventsPerPhase];
  logic        sh_ev_valid [MaxPhases*EventsPerPhase];
  mode_t       sh_mode = MODE_IDLE;
  logic        sh_done = 1'b0;
  int          sh_index = 0;
  int          sh_pos = 0;
  int          fired_cnt;
  logic        fired_drop;

  result_t expected_results[$];
  int errors = 0;
  int n_reqs = 0;
  int n_results = 0;
  int n_fired = 0;
  int n_drops = 0;
  logic calm = 1'b0;
  int stall_cnt = 0;

  initial begin
    for (int i = 0; i < MaxPhases*EventsPerPhase; i++) sh_ev_valid[i] = 1'b0;
    in_ch.valid = 1'b0; in_ch.operation = OP_NONE; in_ch.phase_slot = '0;
    in_ch.event_slot = '0; in_ch.event_present = 1'b0; in_ch.event_tag = '0;
    in_ch.time_value = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_PHASE_COUNT; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic void push_fired(int ph, int slot);
    result_t r;
    if (fired_cnt < MaxFired) begin
      r = '{1'b0, sh_ev_tag[slot], ph[3:0], sh_ev_off[slot][23:0], 1'b0, MODE_IDLE,
            1'b0, 5'd0, 23'd0, 1'b0};
      expected_results = {expected_results, r};
      fired_cnt++;
    end else begin
      fired_drop = 1'b1;
    end
  endfunction

  function automatic void sweep_window(int lo, int hi);
    int slot;
    for (int s = 0; s < EventsPerPhase; s++) begin
      slot = sh_index * EventsPerPhase + s;
      if (sh_ev_valid[slot] &&
          ((lo == 0) ? (sh_ev_off[slot] >= 0 && sh_ev_off[slot] <= hi)
                     : (sh_ev_off[slot] > lo && sh_ev_off[slot] <= hi)))
        push_fired(sh_index, slot);
    end
  endfunction

  function automatic void advance_timeline(int step);
    int rem, cnt, dur, raw;
    rem = (step < 0) ? 0 : step;
    cnt = (sh_phase_count > MaxPhases) ? MaxPhases : sh_phase_count;
    while (rem > 0 && sh_mode == MODE_PLAYING) begin
      if (sh_index >= cnt) begin
        sh_mode = MODE_IDLE; sh_done = 1'b1;
        break;
      end
      dur = (sh_dur[sh_index] < MinDuration) ? MinDuration : sh_dur[sh_index];
      raw = sh_pos + rem;
      if (raw < dur) begin
        sweep_window(sh_pos, raw);
        sh_pos = raw; rem = 0;
      end else begin
        sweep_window(sh_pos, dur);
        rem = raw - dur; sh_index++; sh_pos = 0;
        if (sh_index >= cnt) begin
          sh_mode = MODE_IDLE; sh_done = 1'b1; rem = 0;
        end
      end
    end
  endfunction

  function automatic void predict_request(op_t op, logic [3:0] ps, logic [2:0] es,
                                          logic pres, logic [15:0] tag,
                                          logic signed [23:0] tv);
    result_t r;
    int slot;
    fired_cnt = 0; fired_drop = 1'b0;
    slot = ps * EventsPerPhase + es;
    case (op)
      OP_LOAD_DUR: if (sh_mode == MODE_IDLE) sh_dur[ps] = tv;
      OP_LOAD_EVT: if (sh_mode == MODE_IDLE) begin
        sh_ev_valid[slot] = pres; sh_ev_tag[slot] = tag; sh_ev_off[slot] = tv;
      end
      OP_PLAY: begin
        sh_index = 0; sh_pos = 0;
        if (sh_phase_count == 0) begin
          sh_mode = MODE_IDLE; sh_done = 1'b1;
        end else begin
          sh_mode = MODE_PLAYING; sh_done = 1'b0;
        end
      end
      OP_PAUSE: if (sh_mode == MODE_PLAYING) sh_mode = MODE_PAUSED;
      OP_RESUME: if (sh_mode == MODE_PAUSED) sh_mode = MODE_PLAYING;
      OP_STOP: if (sh_mode != MODE_IDLE && sh_skip) begin
        sh_mode = MODE_IDLE; sh_done = 1'b0; sh_index = 0; sh_pos = 0;
      end
      OP_TICK: if (sh_mode == MODE_PLAYING) advance_timeline(tv);
      default: ;
    endcase
    n_fired += fired_cnt;
    if (fired_drop) n_drops++;
    r = '{1'b1, 16'd0, 4'd0, 24'd0, 1'b1, sh_mode, sh_done, sh_index[4:0],
          sh_pos[22:0], fired_drop};
    expected_results = {expected_results, r};
  endfunction

  function automatic int idle_gap();
    if (calm || $urandom_range(0, 99) >= 33) return 0;
    return $urandom_range(1, 4);
  endfunction

  task automatic send_request(op_t op, logic [3:0] ps, logic [2:0] es, logic pres,
                              logic [15:0] tag, logic signed [23:0] tv);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.operation <= op; in_ch.phase_slot <= ps;
    in_ch.event_slot <= es; in_ch.event_present <= pres; in_ch.event_tag <= tag;
    in_ch.time_value <= tv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_request(op, ps, es, pres, tag, tv);
    n_reqs++;
  endtask

  task automatic send_rand(op_t op, logic signed [23:0] tv);
    send_request(op, 4'($urandom), 3'($urandom), 1'($urandom), 16'($urandom), tv);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [4:0] val);
    drain();
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_PHASE_COUNT) sh_phase_count = val; else sh_skip = val[0];
  endtask

  always @(posedge clk) begin
    out_ch.ready <= (calm || $urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    result_t e;
    if (out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, actual kind=%0d tag=%h", $time,
                 out_ch.item_kind, out_ch.fired_tag);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_ch.item_kind !== e.item_kind || out_ch.fired_tag !== e.fired_tag ||
            out_ch.fired_phase !== e.fired_phase || out_ch.fired_offset !== e.fired_offset ||
            out_ch.run_last !== e.run_last || out_ch.mode !== e.mode ||
            out_ch.finished !== e.finished || out_ch.current_phase !== e.current_phase ||
            out_ch.current_offset !== e.current_offset ||
            out_ch.events_dropped !== e.events_dropped) begin
          $display("%0t: mismatch expected kind=%0d tag=%h ph=%0d off=%0d last=%0d mode=%0d fin=%0d cph=%0d coff=%0d drop=%0d",
                   $time, e.item_kind, e.fired_tag, e.fired_phase, $signed(e.fired_offset),
                   e.run_last, e.mode, e.finished, e.current_phase, e.current_offset,
                   e.events_dropped);
          $display("%0t:          actual kind=%0d tag=%h ph=%0d off=%0d last=%0d mode=%0d fin=%0d cph=%0d coff=%0d drop=%0d",
                   $time, out_ch.item_kind, out_ch.fired_tag, out_ch.fired_phase,
                   out_ch.fired_offset, out_ch.run_last, out_ch.mode, out_ch.finished,
                   out_ch.current_phase, out_ch.current_offset, out_ch.events_dropped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= 20000) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // every duration gets written before any play can read it
  task automatic test_extremes();
    for (int p = 0; p < MaxPhases; p++)
      send_request(OP_LOAD_DUR, p[3:0], 3'($urandom), 1'($urandom), 16'($urandom),
                   (p == 0) ? 24'sh7FFFFF : (p == 1) ? 24'sh800000 :
                   24'($urandom_range(0, 60)));
    send_request(OP_LOAD_EVT, 4'd2, 3'd7, 1'b1, 16'hFFFF, 24'sd0);
    send_request(OP_LOAD_EVT, 4'd2, 3'd0, 1'b1, 16'h0000, 24'sd16);
    send_request(OP_LOAD_EVT, 4'd3, 3'd3, 1'b1, 16'hA5A5, -24'sd5);
    send_request(OP_LOAD_EVT, 4'd15, 3'd7, 1'b0, 16'h5A5A, 24'sd3);
  endtask

  task automatic test_modes();
    write_reg(CFG_PHASE_COUNT, 5'd0);
    send_rand(OP_PLAY, 24'sd0);
    send_rand(OP_TICK, 24'sd20);
    write_reg(CFG_PHASE_COUNT, 5'd31);
    send_rand(OP_PLAY, 24'sd0);
    send_rand(OP_TICK, -24'sd8);
    send_rand(OP_TICK, 24'sd0);
    send_rand(OP_PAUSE, 24'sd0);
    send_rand(OP_TICK, 24'sd40);
    send_rand(OP_LOAD_DUR, 24'sd1);
    send_rand(OP_RESUME, 24'sd0);
    send_rand(OP_TICK, 24'sh7FFFFF);
    send_rand(OP_TICK, 24'sh7FFFFF);
    write_reg(CFG_SKIP_ALLOWED, 5'd0);
    send_rand(OP_PLAY, 24'sd0);
    send_rand(OP_STOP, 24'sd0);
    write_reg(CFG_SKIP_ALLOWED, 5'd1);
    send_rand(OP_STOP, 24'sd0);
    send_rand(OP_NONE, 24'sd0);
  endtask

  task automatic test_drop_overflow();
    calm = 1'b1;
    for (int p = 0; p < 8; p++) begin
      send_request(OP_LOAD_DUR, p[3:0], 3'd0, 1'b0, 16'd0, 24'($urandom_range(0, 16)));
      for (int s = 0; s < EventsPerPhase; s++)
        send_request(OP_LOAD_EVT, p[3:0], s[2:0], 1'b1, 16'($urandom),
                     24'($urandom_range(0, 16)));
    end
    write_reg(CFG_PHASE_COUNT, 5'd8);
    send_rand(OP_PLAY, 24'sd0);
    send_rand(OP_TICK, 24'sd1000);
    calm = 1'b0;
  endtask

  task automatic test_random_timelines();
    logic signed [23:0] tv;
    int n;
    repeat (2) begin
      write_reg(CFG_PHASE_COUNT, 5'($urandom_range(0, 17)));
      write_reg(CFG_SKIP_ALLOWED, 5'($urandom_range(0, 1)));
      n = $urandom_range(2, 6);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0)
          send_rand(OP_LOAD_DUR, ($urandom_range(0, 7) == 0) ? 24'($urandom) :
                                 24'($urandom_range(0, 80)));
        else
          send_rand(OP_LOAD_EVT, ($urandom_range(0, 7) == 0) ? 24'($urandom) :
                                 24'($urandom_range(0, 80)) - 24'sd4);
      end
      send_rand(OP_PLAY, 24'($urandom));
      n = $urandom_range(3, 8);
      repeat (n) begin
        case ($urandom_range(0, 15))
          0: send_rand(OP_PAUSE, 24'($urandom));
          1: send_rand(OP_RESUME, 24'($urandom));
          2: send_rand(OP_STOP, 24'($urandom));
          3: send_rand(op_t'(3'($urandom)), 24'($urandom));
          default: begin
            tv = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 90));
            send_rand(OP_TICK, tv);
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_modes();
    test_drop_overflow();
    test_random_timelines();
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d fired events, %0d overflowing ticks",
             n_reqs, n_results, n_fired, n_drops);
    $display("with phase counts 0..31, stop gating, pause/resume and phase crossing");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
